FILE: design/particle_pool_euler_update_assert.svh
// Assertion helpers for the particle pool.
`ifndef PARTICLE_POOL_EULER_UPDATE_ASSERT_SVH
`define PARTICLE_POOL_EULER_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define PPEU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPEU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ppeu_pkg.sv
package ppeu_pkg;

   localparam int PoolSizeDefault = 64;

   localparam logic [1:0] FUNC_SPAWN = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_PART  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   localparam logic [2:0] MulLast = 3'd6;

   typedef enum logic [1:0] {
      SRC_SPAWN,
      SRC_CLEAR,
      SRC_PART,
      SRC_EMPTY
   } out_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPAWN,
      ST_CLEAR,
      ST_T_RD,
      ST_T_MOVE,
      ST_T_WAIT,
      ST_T_CHK,
      ST_T_MUL,
      ST_T_WR,
      ST_E_INIT,
      ST_E_RD,
      ST_E_OUT,
      ST_E_EMPTY
   } state_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_z;
      logic [31:0] acc_x;
      logic [31:0] acc_y;
      logic [31:0] acc_z;
      logic [31:0] life;
   } particle_type;

   typedef struct packed {
      logic        req_load;
      logic        spawn_wr;
      logic        clr;
      logic        rd_en;
      logic        rd_last;
      logic        rec_load;
      logic        life_sub;
      logic        mul_en;
      logic [2:0]  mul_sel;
      logic        cnt_dec;
      logic        idx_clr;
      logic        idx_inc;
      logic        wr_en;
      logic        out_load;
      out_src_type out_src;
   } cmd_type;

   typedef struct packed {
      logic dies;
      logic idx_end;
      logic idx_last;
      logic cnt_zero;
      logic out_free;
   } status_type;

endpackage

FILE: design/ppeu_ram.sv
module ppeu_ram #(
   parameter int Width = 32,
   parameter int Depth = 64,
   localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [Aw-1:0]    wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [Aw-1:0]    rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ppeu_ctrl.sv
module ppeu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   input  ppeu_pkg::status_type status,
   output ppeu_pkg::cmd_type    cmd,
   output logic                req_stall
);
   import ppeu_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FUNC_SPAWN: state_in = ST_SPAWN;
                  FUNC_CLEAR: state_in = ST_CLEAR;
                  FUNC_TICK:  state_in = ST_T_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SPAWN, ST_CLEAR, ST_E_EMPTY: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_T_RD, ST_T_MOVE: begin
            state_in = status.idx_end ? ST_E_INIT : ST_T_WAIT;
         end
         ST_T_WAIT: state_in = ST_T_CHK;
         ST_T_CHK: begin
            step_in  = '0;
            state_in = status.dies ? ST_T_MOVE : ST_T_MUL;
         end
         ST_T_MUL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == MulLast) state_in = ST_T_WR;
         end
         ST_T_WR:   state_in = ST_T_RD;
         ST_E_INIT: state_in = status.cnt_zero ? ST_E_EMPTY : ST_E_RD;
         ST_E_RD:   state_in = ST_E_OUT;
         ST_E_OUT: begin
            if (status.out_free) state_in = status.idx_last ? ST_IDLE : ST_E_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.out_src = SRC_PART;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.req_load = req_valid;
            cmd.idx_clr  = req_valid;
         end
         ST_SPAWN: begin
            cmd.spawn_wr = status.out_free;
            cmd.out_load = status.out_free;
            cmd.out_src  = SRC_SPAWN;
         end
         ST_CLEAR: begin
            cmd.clr      = status.out_free;
            cmd.out_load = status.out_free;
            cmd.out_src  = SRC_CLEAR;
         end
         ST_T_RD:   cmd.rd_en = !status.idx_end;
         ST_T_MOVE: begin
            // re-examine the slot with the last live particle in it
            cmd.rd_en   = !status.idx_end;
            cmd.rd_last = 1'b1;
         end
         ST_T_WAIT: cmd.rec_load = 1'b1;
         ST_T_CHK: begin
            cmd.cnt_dec  = status.dies;
            cmd.life_sub = !status.dies;
         end
         ST_T_MUL: begin
            cmd.mul_en  = (step_ff != MulLast);
            cmd.mul_sel = step_ff;
         end
         ST_T_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ST_E_INIT: cmd.idx_clr = 1'b1;
         ST_E_RD:   cmd.rd_en   = 1'b1;
         ST_E_OUT: begin
            cmd.out_load = status.out_free;
            cmd.idx_inc  = status.out_free;
            cmd.out_src  = SRC_PART;
         end
         ST_E_EMPTY: begin
            cmd.out_load = status.out_free;
            cmd.out_src  = SRC_EMPTY;
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: design/ppeu_dpath.sv
module ppeu_dpath #(
   parameter int POOL_SIZE = ppeu_pkg::PoolSizeDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ppeu_pkg::cmd_type    cmd,
   output ppeu_pkg::status_type status,
   input  logic [20:0]          req_dt,
   input  logic [31:0]          req_new_pos_x,
   input  logic [31:0]          req_new_pos_y,
   input  logic [31:0]          req_new_pos_z,
   input  logic [31:0]          req_new_vel_x,
   input  logic [31:0]          req_new_vel_y,
   input  logic [31:0]          req_new_vel_z,
   input  logic [31:0]          req_new_acc_x,
   input  logic [31:0]          req_new_acc_y,
   input  logic [31:0]          req_new_acc_z,
   input  logic [31:0]          req_new_life,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_kind,
   output logic                 rsp_pool_full,
   output logic [5:0]           rsp_slot,
   output logic [31:0]          rsp_out_pos_x,
   output logic [31:0]          rsp_out_pos_y,
   output logic [31:0]          rsp_out_pos_z,
   output logic [31:0]          rsp_out_life,
   output logic [6:0]           rsp_live_total,
   output logic                 rsp_last
);
   import ppeu_pkg::*;

   localparam int Aw = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int Cw = $clog2(POOL_SIZE + 1);
   localparam int PartW = $bits(particle_type);

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [53:0] p);
      logic signed [38:0] s;
      s = 39'($signed(a)) + 39'($signed(p[53:16]));
      if (s > 39'sd2147483647) return 32'h7fff_ffff;
      if (s < -39'sd2147483648) return 32'h8000_0000;
      return s[31:0];
   endfunction

   particle_type req_ff, rec_ff, rd_part, wr_part;
   logic [20:0]  dt_ff;
   logic [Cw-1:0] count_ff, idx_ff;
   logic signed [53:0] prod_ff;
   logic         acc_en_ff;
   logic [2:0]   acc_sel_ff;
   logic [31:0]  mul_op;
   logic         full;
   logic [Aw-1:0] wr_addr, rd_addr;
   logic [PartW-1:0] rd_bits;

   logic         rsp_valid_ff;
   logic [1:0]   kind_ff;
   logic         pool_full_ff, last_ff;
   logic [5:0]   slot_ff;
   logic [31:0]  pos_x_ff, pos_y_ff, pos_z_ff, life_ff;
   logic [6:0]   live_total_ff;

   assign full    = (count_ff >= Cw'(POOL_SIZE));
   assign rd_part = particle_type'(rd_bits);
   assign wr_part = cmd.spawn_wr ? req_ff : rec_ff;
   assign wr_addr = cmd.spawn_wr ? count_ff[Aw-1:0] : idx_ff[Aw-1:0];
   assign rd_addr = cmd.rd_last ? count_ff[Aw-1:0] : idx_ff[Aw-1:0];

   ppeu_ram #(
      .Width(PartW),
      .Depth(POOL_SIZE)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en || (cmd.spawn_wr && !full)),
      .wr_addr(wr_addr),
      .wr_data(wr_part),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   always_comb begin
      case (cmd.mul_sel)
         3'd0:    mul_op = rec_ff.acc_x;
         3'd1:    mul_op = rec_ff.acc_y;
         3'd2:    mul_op = rec_ff.acc_z;
         3'd3:    mul_op = rec_ff.vel_x;
         3'd4:    mul_op = rec_ff.vel_y;
         default: mul_op = rec_ff.vel_z;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         dt_ff        <= req_dt;
         req_ff.pos_x <= req_new_pos_x;
         req_ff.pos_y <= req_new_pos_y;
         req_ff.pos_z <= req_new_pos_z;
         req_ff.vel_x <= req_new_vel_x;
         req_ff.vel_y <= req_new_vel_y;
         req_ff.vel_z <= req_new_vel_z;
         req_ff.acc_x <= req_new_acc_x;
         req_ff.acc_y <= req_new_acc_y;
         req_ff.acc_z <= req_new_acc_z;
         req_ff.life  <= req_new_life;
      end
      if (cmd.mul_en) begin
         prod_ff <= 54'($signed(mul_op)) * 54'($signed({1'b0, dt_ff}));
      end
      acc_sel_ff <= cmd.mul_sel;
      if (cmd.rec_load) begin
         rec_ff <= rd_part;
      end else if (cmd.life_sub) begin
         rec_ff.life <= rec_ff.life - {11'd0, dt_ff};
      end else if (acc_en_ff) begin
         // velocity first, then position from the updated velocity
         case (acc_sel_ff)
            3'd0:    rec_ff.vel_x <= sat_add(rec_ff.vel_x, prod_ff);
            3'd1:    rec_ff.vel_y <= sat_add(rec_ff.vel_y, prod_ff);
            3'd2:    rec_ff.vel_z <= sat_add(rec_ff.vel_z, prod_ff);
            3'd3:    rec_ff.pos_x <= sat_add(rec_ff.pos_x, prod_ff);
            3'd4:    rec_ff.pos_y <= sat_add(rec_ff.pos_y, prod_ff);
            default: rec_ff.pos_z <= sat_add(rec_ff.pos_z, prod_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         idx_ff    <= '0;
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.mul_en;
         if (cmd.clr) begin
            count_ff <= '0;
         end else if (cmd.spawn_wr && !full) begin
            count_ff <= count_ff + Cw'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - Cw'(1);
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + Cw'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff       <= KIND_ACK;
         pool_full_ff  <= 1'b0;
         slot_ff       <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         pos_z_ff      <= '0;
         life_ff       <= '0;
         live_total_ff <= 7'(count_ff);
         last_ff       <= 1'b1;
         case (cmd.out_src)
            SRC_SPAWN: begin
               if (full) begin
                  pool_full_ff <= 1'b1;
               end else begin
                  slot_ff       <= 6'(count_ff);
                  pos_x_ff      <= req_ff.pos_x;
                  pos_y_ff      <= req_ff.pos_y;
                  pos_z_ff      <= req_ff.pos_z;
                  life_ff       <= req_ff.life;
                  live_total_ff <= 7'(count_ff) + 7'd1;
               end
            end
            SRC_CLEAR: live_total_ff <= '0;
            SRC_PART: begin
               kind_ff  <= KIND_PART;
               slot_ff  <= 6'(idx_ff);
               pos_x_ff <= rd_part.pos_x;
               pos_y_ff <= rd_part.pos_y;
               pos_z_ff <= rd_part.pos_z;
               life_ff  <= rd_part.life;
               last_ff  <= status.idx_last;
            end
            SRC_EMPTY: kind_ff <= KIND_EMPTY;
            default:   kind_ff <= KIND_ACK;
         endcase
      end
   end

   assign status.dies     = (rec_ff.life <= {11'd0, dt_ff});
   assign status.idx_end  = (idx_ff >= count_ff);
   assign status.idx_last = ((idx_ff + Cw'(1)) == count_ff);
   assign status.cnt_zero = (count_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_pool_full  = pool_full_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_out_pos_x  = pos_x_ff;
   assign rsp_out_pos_y  = pos_y_ff;
   assign rsp_out_pos_z  = pos_z_ff;
   assign rsp_out_life   = life_ff;
   assign rsp_live_total = live_total_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: design/particle_pool_euler_update.sv
// Compacted particle pool with a semi-implicit Euler step in Q16.16. A spawn
// request appends a particle (or answers pool full), a clear request empties
// the pool; each answers with one result. A tick request walks the live slots
// through one RAM with a read port and a write port and a single shared 32x22
// multiplier: a survivor is read, has its life checked, goes through six
// multiplies with saturating accumulate and is written back; a removed
// particle's slot is refilled from the last live slot. Then every survivor
// is emitted, or one empty result if none is left. One request is in work at
// a time; the next is taken once the last result sits in the output register.
module particle_pool_euler_update #(
   parameter int POOL_SIZE = ppeu_pkg::PoolSizeDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [20:0] req_dt,
   input  logic [31:0] req_new_pos_x,
   input  logic [31:0] req_new_pos_y,
   input  logic [31:0] req_new_pos_z,
   input  logic [31:0] req_new_vel_x,
   input  logic [31:0] req_new_vel_y,
   input  logic [31:0] req_new_vel_z,
   input  logic [31:0] req_new_acc_x,
   input  logic [31:0] req_new_acc_y,
   input  logic [31:0] req_new_acc_z,
   input  logic [31:0] req_new_life,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_pool_full,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_out_pos_x,
   output logic [31:0] rsp_out_pos_y,
   output logic [31:0] rsp_out_pos_z,
   output logic [31:0] rsp_out_life,
   output logic [6:0]  rsp_live_total,
   output logic        rsp_last
);
   import ppeu_pkg::*;

   cmd_type    cmd;
   status_type status;

   ppeu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .req_stall(req_stall)
   );

   ppeu_dpath #(
      .POOL_SIZE(POOL_SIZE)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_dt        (req_dt),
      .req_new_pos_x (req_new_pos_x),
      .req_new_pos_y (req_new_pos_y),
      .req_new_pos_z (req_new_pos_z),
      .req_new_vel_x (req_new_vel_x),
      .req_new_vel_y (req_new_vel_y),
      .req_new_vel_z (req_new_vel_z),
      .req_new_acc_x (req_new_acc_x),
      .req_new_acc_y (req_new_acc_y),
      .req_new_acc_z (req_new_acc_z),
      .req_new_life  (req_new_life),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_pool_full (rsp_pool_full),
      .rsp_slot      (rsp_slot),
      .rsp_out_pos_x (rsp_out_pos_x),
      .rsp_out_pos_y (rsp_out_pos_y),
      .rsp_out_pos_z (rsp_out_pos_z),
      .rsp_out_life  (rsp_out_life),
      .rsp_live_total(rsp_live_total),
      .rsp_last      (rsp_last)
   );

`include "particle_pool_euler_update_assert.svh"

   `PPEU_ASSERT_NOW(a_part_in_range, clock, reset, rsp_valid && (rsp_kind == KIND_PART), (7'(rsp_slot) < rsp_live_total), "reported slot beyond live count")
   `PPEU_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && rsp_pool_full, (rsp_live_total == 7'(POOL_SIZE)), "pool full reported below capacity")
   `PPEU_ASSERT_NOW(a_port_conflict, clock, reset, cmd.rd_en, !(cmd.wr_en || cmd.spawn_wr), "RAM read and write in the same cycle")
   `PPEU_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid, "loaded result not presented")

endmodule
